FILE: sv/aeu_pkg.sv
`default_nettype none

package aeu_pkg;

  // Width of the signed Q16.16 weight delta; the clamp bounds follow from it.
  localparam int VALUE_BITS = 32;

  // Field widths of the element beats and of the configuration registers.
  localparam int ADDR_W     = 12;
  localparam int GRAD_W     = 32;
  localparam int DELTA_W    = VALUE_BITS;
  localparam int STORE_W    = 32;
  localparam int LR_W       = 17;
  localparam int BETA_W     = 16;
  localparam int EPS_W      = 17;
  localparam int BATCH_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Q16.16 one, also the unit for the Q0.16 decay fractions.
  localparam logic [BETA_W:0] ONE_Q16 = 17'h10000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE     = 3'd0,
    CFG_BETA_FIRST        = 3'd1,
    CFG_BETA_SECOND       = 3'd2,
    CFG_BETA_FIRST_POWER  = 3'd3,
    CFG_BETA_SECOND_POWER = 3'd4,
    CFG_EPSILON_TERM      = 3'd5,
    CFG_BATCH_COUNT       = 3'd6
  } cfg_index_t;

endpackage

`default_nettype wire

FILE: sv/aeu_in_if.sv
`default_nettype none

interface aeu_in_if;
  import aeu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        element_address;
  logic signed [GRAD_W-1:0] gradient_sum;
  logic                     last_in;

  modport source (output valid, output element_address, output gradient_sum,
                  output last_in, input ready);
  modport sink (input valid, input element_address, input gradient_sum,
                input last_in, output ready);
endinterface

`default_nettype wire

FILE: sv/aeu_out_if.sv
`default_nettype none

interface aeu_out_if;
  import aeu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ADDR_W-1:0]         result_address;
  logic signed [DELTA_W-1:0] weight_delta;
  logic                      saturated;
  logic                      last_out;

  modport source (output valid, output result_address, output weight_delta,
                  output saturated, output last_out, input ready);
  modport sink (input valid, input result_address, input weight_delta,
                input saturated, input last_out, output ready);
endinterface

`default_nettype wire

FILE: sv/aeu_ram.sv
`default_nettype none

module aeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/aeu_div.sv
`default_nettype none

module aeu_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic      [NW-1:0] quot,
  output logic      [SW-1:0] side_out
);

  // One quotient bit per stage; acc holds the unused numerator bits on top
  // and the quotient bits found so far below.
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] acc_r  [NW];
  logic [DW-1:0] den_r  [NW];
  logic [SW-1:0] side_r [NW];
  logic [NW-1:0] vld_r;

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [DW-1:0] rem_p;
    logic [NW-1:0] acc_p;
    logic [DW-1:0] den_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [DW:0]   cat;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign acc_p  = num;
      assign den_p  = den;
      assign side_p = side_in;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign acc_p  = acc_r[i-1];
      assign den_p  = den_r[i-1];
      assign side_p = side_r[i-1];
      assign vld_p  = vld_r[i-1];
    end

    // Restoring step: bring down one numerator bit, subtract if it fits.
    assign cat  = {rem_p, acc_p[NW-1]};
    assign diff = cat - {1'b0, den_p};
    assign ge   = (cat >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DW-1:0] : cat[DW-1:0];
        acc_r[i]  <= {acc_p[NW-2:0], ge};
        den_r[i]  <= den_p;
        side_r[i] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign quot      = acc_r[NW-1];
  assign side_out  = side_r[NW-1];

endmodule

`default_nettype wire

FILE: sv/aeu_sqrt.sv
`default_nettype none

module aeu_sqrt #(
  parameter int RW = 32,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*RW-1:0] x,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic      [RW-1:0]   root,
  output logic      [SW-1:0]   side_out
);

  // One root bit per stage, consuming two radicand bits each.
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] x_r    [RW];
  logic [SW-1:0]   side_r [RW];
  logic [RW-1:0]   vld_r;

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RW+1:0]   rem_p;
    logic [RW-1:0]   root_p;
    logic [2*RW-1:0] x_p;
    logic [SW-1:0]   side_p;
    logic            vld_p;
    logic [RW+3:0]   cat;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x;
      assign side_p = side_in;
      assign vld_p  = in_valid;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign x_p    = x_r[i-1];
      assign side_p = side_r[i-1];
      assign vld_p  = vld_r[i-1];
    end

    // Trial subtract of 4*root+1 from the remainder with the next bit pair.
    assign cat   = {rem_p, x_p[2*RW-1 -: 2]};
    assign trial = {2'b00, root_p, 2'b01};
    assign diff  = cat - trial;
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[RW+1:0] : cat[RW+1:0];
        root_r[i] <= {root_p[RW-2:0], ge};
        x_r[i]    <= {x_p[2*RW-3:0], 2'b00};
        side_r[i] <= side_p;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_p;
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root      = root_r[RW-1];
  assign side_out  = side_r[RW-1];

endmodule

`default_nettype wire

FILE: sv/adam_element_update_core.sv
`default_nettype none

// Adam update of one parameter element per beat.
// in_ch carries an element address, its batch-summed Q16.16 gradient and a
// last flag. out_ch returns, for every input beat and in the same order, the
// address, the saturated Q16.16 weight delta, a saturation flag and the last
// flag. Registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while no element is in flight, and the block itself
// does not enforce it. The first and second moments of every element sit in
// two RAMs that are read, updated and written back one element per cycle
// while out_ch is not stalled, with forwarding when the same element follows
// itself. Dividers and the square root are fully pipelined, so one beat is
// taken every cycle unless out_ch stalls or the moment RAMs are being cleared.
// A beat passes through the batch divide, the moment update, the bias
// correction, the square root, the final divide, the learning-rate product
// and the output register. After reset the moment RAMs are cleared one entry
// a cycle, all ELEMENT_COUNT entries, while in_ch.ready stays low. When
// out_ch is stalled the whole pipeline holds; the output register lets a new
// beat enter as the held result is taken.
module adam_element_update_core #(
  parameter int ELEMENT_COUNT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  aeu_in_if.sink                              in_ch,
  aeu_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [aeu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aeu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import aeu_pkg::*;

  localparam int AW        = $clog2(ELEMENT_COUNT);
  localparam bit REDUCE    = ELEMENT_COUNT < (1 << ADDR_W);
  localparam int MOD_SH    = 26;
  localparam int RECIP     = ((1 << MOD_SH) + ELEMENT_COUNT - 1) / ELEMENT_COUNT;
  localparam int RECIP_W   = MOD_SH + 1;
  localparam logic [63:0] POS_MAX = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
  localparam logic [63:0] NEG_MAX = 64'd1 << (VALUE_BITS - 1);
  localparam int D1_SW     = ADDR_W + 2;
  localparam int D2_SW     = ADDR_W + 1;
  localparam int SQ_SW     = 48 + ADDR_W + 2;
  localparam int D4_SW     = ADDR_W + 3;

  // Configuration registers.
  logic [LR_W-1:0]    learning_rate_r;
  logic [BETA_W-1:0]  beta_first_r;
  logic [BETA_W-1:0]  beta_second_r;
  logic [BETA_W-1:0]  beta_first_power_r;
  logic [BETA_W-1:0]  beta_second_power_r;
  logic [EPS_W-1:0]   epsilon_term_r;
  logic [BATCH_W-1:0] batch_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r     <= 17'd66;
      beta_first_r        <= 16'd58982;
      beta_second_r       <= 16'd65470;
      beta_first_power_r  <= 16'd58982;
      beta_second_power_r <= 16'd65470;
      epsilon_term_r      <= 17'd1;
      batch_count_r       <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_LEARNING_RATE:     learning_rate_r     <= cfg_wdata[LR_W-1:0];
        CFG_BETA_FIRST:        beta_first_r        <= cfg_wdata[BETA_W-1:0];
        CFG_BETA_SECOND:       beta_second_r       <= cfg_wdata[BETA_W-1:0];
        CFG_BETA_FIRST_POWER:  beta_first_power_r  <= cfg_wdata[BETA_W-1:0];
        CFG_BETA_SECOND_POWER: beta_second_power_r <= cfg_wdata[BETA_W-1:0];
        CFG_EPSILON_TERM:      epsilon_term_r      <= cfg_wdata[EPS_W-1:0];
        CFG_BATCH_COUNT:       batch_count_r       <= cfg_wdata[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a held result is not taken.
  logic out_valid_r;
  logic advance;
  logic clearing_r;
  logic [AW-1:0] clr_idx_r;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance && !clearing_r;

  // Clearing pass over both moment RAMs after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(ELEMENT_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Gradient magnitude divided by the batch count.
  logic [GRAD_W-1:0]  gs_u;
  logic               gneg;
  logic [GRAD_W-1:0]  gmag;
  logic [BATCH_W-1:0] bc;
  logic               d1_valid;
  logic [GRAD_W-1:0]  d1_q;
  logic [D1_SW-1:0]   d1_side;

  assign gs_u = in_ch.gradient_sum;
  assign gneg = gs_u[GRAD_W-1];
  assign gmag = gneg ? (GRAD_W'(0) - gs_u) : gs_u;
  assign bc   = (batch_count_r == '0) ? BATCH_W'(1) : batch_count_r;

  aeu_div #(.NW(GRAD_W), .DW(BATCH_W), .SW(D1_SW)) u_div_grad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (in_ch.valid && in_ch.ready),
    .num       (gmag),
    .den       (bc),
    .side_in   ({gneg, in_ch.last_in, in_ch.element_address}),
    .out_valid (d1_valid),
    .quot      (d1_q),
    .side_out  (d1_side)
  );

  // Stage P1: signed gradient, clipped square, address quotient.
  logic                     p1_valid_r;
  logic [ADDR_W-1:0]        p1_addr_r;
  logic                     p1_last_r;
  logic signed [GRAD_W-1:0] p1_g_r;
  logic [STORE_W-1:0]       p1_gg_r;
  logic [ADDR_W-1:0]        p1_aq_r;
  logic [2*GRAD_W-1:0]      gsq;
  logic [ADDR_W+RECIP_W-1:0] aq_full;

  assign gsq     = 64'(d1_q) * 64'(d1_q);
  assign aq_full = (ADDR_W + RECIP_W)'(d1_side[ADDR_W-1:0]) *
                   (ADDR_W + RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (advance) begin
      p1_valid_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p1_addr_r <= d1_side[ADDR_W-1:0];
      p1_last_r <= d1_side[ADDR_W];
      p1_g_r    <= d1_side[ADDR_W+1] ? (GRAD_W'(0) - d1_q) : d1_q;
      p1_gg_r   <= (|gsq[63:48]) ? '1 : gsq[47:16];
      p1_aq_r   <= aq_full[MOD_SH +: ADDR_W];
    end
  end

  // RAM read address: element address reduced modulo the element count.
  logic [ADDR_W-1:0] rem_a;
  logic [AW-1:0]     rd_addr;

  assign rem_a   = p1_addr_r -
                   ADDR_W'((2*ADDR_W)'(p1_aq_r) * (2*ADDR_W)'(ELEMENT_COUNT));
  assign rd_addr = REDUCE ? AW'(rem_a) : AW'(p1_addr_r);

  // Stage P2: moment read-modify-write.
  logic                     p2_valid_r;
  logic [ADDR_W-1:0]        p2_addr_r;
  logic                     p2_last_r;
  logic [AW-1:0]            p2_waddr_r;
  logic signed [49:0]       p2_t1_r;
  logic [48:0]              p2_t2_r;
  logic [BETA_W:0]          omb1;
  logic [BETA_W:0]          omb2;

  assign omb1 = ONE_Q16 - {1'b0, beta_first_r};
  assign omb2 = ONE_Q16 - {1'b0, beta_second_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (advance) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p2_addr_r  <= p1_addr_r;
      p2_last_r  <= p1_last_r;
      p2_waddr_r <= rd_addr;
      p2_t1_r    <= 50'($signed({1'b0, omb1})) * 50'(p1_g_r);
      p2_t2_r    <= 49'(omb2) * 49'(p1_gg_r);
    end
  end

  logic [STORE_W-1:0]        m_rd;
  logic [STORE_W-1:0]        v_rd;
  logic                      fwd_hit_r;
  logic [STORE_W-1:0]        fwd_m_r;
  logic [STORE_W-1:0]        fwd_v_r;
  logic signed [STORE_W-1:0] m_old;
  logic [STORE_W-1:0]        v_old;
  logic signed [48:0]        prod1;
  logic signed [50:0]        sum1;
  logic [47:0]               prod2;
  logic [49:0]               sum2;
  logic [STORE_W-1:0]        mn;
  logic [STORE_W-1:0]        vn;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;

  // A write in the same cycle as the read of that entry is forwarded.
  assign m_old = fwd_hit_r ? fwd_m_r : m_rd;
  assign v_old = fwd_hit_r ? fwd_v_r : v_rd;
  assign prod1 = 49'($signed({1'b0, beta_first_r})) * 49'(m_old);
  assign sum1  = 51'(prod1) + 51'(p2_t1_r);
  assign mn    = sum1[47:16];
  assign prod2 = 48'(beta_second_r) * 48'(v_old);
  assign sum2  = 50'(prod2) + 50'(p2_t2_r);
  assign vn    = sum2[47:16];

  assign ram_we    = clearing_r || (advance && p2_valid_r);
  assign ram_waddr = clearing_r ? clr_idx_r : p2_waddr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (advance) begin
      fwd_hit_r <= p2_valid_r && (p2_waddr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fwd_m_r <= mn;
      fwd_v_r <= vn;
    end
  end

  aeu_ram #(.WIDTH(STORE_W), .DEPTH(ELEMENT_COUNT)) u_ram_first (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (clearing_r ? '0 : mn),
    .re    (advance),
    .raddr (rd_addr),
    .rdata (m_rd)
  );

  aeu_ram #(.WIDTH(STORE_W), .DEPTH(ELEMENT_COUNT)) u_ram_second (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (clearing_r ? '0 : vn),
    .re    (advance),
    .raddr (rd_addr),
    .rdata (v_rd)
  );

  // Stage P3: sign and magnitude of the new first moment.
  logic               p3_valid_r;
  logic [ADDR_W-1:0]  p3_addr_r;
  logic               p3_last_r;
  logic               p3_mneg_r;
  logic [STORE_W-1:0] p3_mabs_r;
  logic [STORE_W-1:0] p3_vn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (advance) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p3_addr_r <= p2_addr_r;
      p3_last_r <= p2_last_r;
      p3_mneg_r <= mn[STORE_W-1];
      p3_mabs_r <= mn[STORE_W-1] ? (STORE_W'(0) - mn) : mn;
      p3_vn_r   <= vn;
    end
  end

  // Bias correction of both moments.
  logic             d2_valid;
  logic [47:0]      d2_q;
  logic [D2_SW-1:0] d2_side;
  logic             d3_valid;
  logic [47:0]      d3_q;
  logic             d3_mneg;

  aeu_div #(.NW(48), .DW(BETA_W + 1), .SW(D2_SW)) u_div_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (p3_valid_r),
    .num       ({p3_mabs_r, 16'd0}),
    .den       (ONE_Q16 - {1'b0, beta_first_power_r}),
    .side_in   ({p3_last_r, p3_addr_r}),
    .out_valid (d2_valid),
    .quot      (d2_q),
    .side_out  (d2_side)
  );

  aeu_div #(.NW(48), .DW(BETA_W + 1), .SW(1)) u_div_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (p3_valid_r),
    .num       ({p3_vn_r, 16'd0}),
    .den       (ONE_Q16 - {1'b0, beta_second_power_r}),
    .side_in   (p3_mneg_r),
    .out_valid (d3_valid),
    .quot      (d3_q),
    .side_out  (d3_mneg)
  );

  // Square root of the corrected second moment.
  logic             sq_valid;
  logic [31:0]      sq_root;
  logic [SQ_SW-1:0] sq_side;

  aeu_sqrt #(.RW(32), .SW(SQ_SW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (d2_valid),
    .x         ({d3_q, 16'd0}),
    .side_in   ({d2_q, d3_mneg, d2_side}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // Final quotient of the corrected first moment over root plus epsilon.
  logic [32:0]      den;
  logic             d4_valid;
  logic [63:0]      d4_q;
  logic [D4_SW-1:0] d4_side;

  assign den = {1'b0, sq_root} + 33'(epsilon_term_r);

  aeu_div #(.NW(64), .DW(33), .SW(D4_SW)) u_div_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .in_valid  (sq_valid),
    .num       ({sq_side[SQ_SW-1 -: 48], 16'd0}),
    .den       (den),
    .side_in   ({den == 33'd0, sq_side[ADDR_W+1:0]}),
    .out_valid (d4_valid),
    .quot      (d4_q),
    .side_out  (d4_side)
  );

  // Stage P5: learning-rate product.
  logic              p5_valid_r;
  logic [ADDR_W-1:0] p5_addr_r;
  logic              p5_last_r;
  logic              p5_mneg_r;
  logic              p5_dz_r;
  logic              p5_huge_r;
  logic              p5_lrz_r;
  logic [47:0]       p5_mag_r;
  logic [63:0]       prod5;

  assign prod5 = 64'(d4_q[46:0]) * 64'(learning_rate_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_valid_r <= 1'b0;
    end else if (advance) begin
      p5_valid_r <= d4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p5_addr_r <= d4_side[ADDR_W-1:0];
      p5_last_r <= d4_side[ADDR_W];
      p5_mneg_r <= d4_side[ADDR_W+1];
      p5_dz_r   <= d4_side[ADDR_W+2];
      p5_huge_r <= |d4_q[63:47];
      p5_lrz_r  <= (learning_rate_r == '0);
      p5_mag_r  <= prod5[63:16];
    end
  end

  // Clamp, sign and output register.
  logic [63:0]  mag64;
  logic [63:0]  delta_nxt;
  logic         sat_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [DELTA_W-1:0] out_delta_r;
  logic               out_sat_r;
  logic               out_last_r;

  always_comb begin
    mag64     = p5_lrz_r ? 64'd0 : (p5_huge_r ? '1 : 64'(p5_mag_r));
    delta_nxt = 64'd0;
    sat_nxt   = 1'b0;
    if (!p5_dz_r) begin
      if (p5_mneg_r) begin
        if (mag64 > POS_MAX) begin
          mag64   = POS_MAX;
          sat_nxt = 1'b1;
        end
        delta_nxt = mag64;
      end else begin
        if (mag64 > NEG_MAX) begin
          mag64   = NEG_MAX;
          sat_nxt = 1'b1;
        end
        delta_nxt = 64'd0 - mag64;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= p5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_addr_r  <= p5_addr_r;
      out_delta_r <= delta_nxt[DELTA_W-1:0];
      out_sat_r   <= sat_nxt;
      out_last_r  <= p5_last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.weight_delta   = out_delta_r;
  assign out_ch.saturated      = out_sat_r;
  assign out_ch.last_out       = out_last_r;

`ifndef ASSERT_OFF
  // No element enters while the moment RAMs are being cleared.
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

  // No moment write-back can collide with the clearing pass.
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !p2_valid_r)
    else $error("moment update during clearing pass");

  // The two bias-correction dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    d2_valid == d3_valid)
    else $error("bias-correction dividers out of step");

  // A forwarded entry came from an element that advanced out of the update stage.
  a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_hit_r) |-> $past(p2_valid_r && advance))
    else $error("forwarding without a preceding write");
`endif

endmodule

`default_nettype wire

FILE: tb/adam_element_update_core_tb.sv
`default_nettype none

module adam_element_update_core_tb;
  import aeu_pkg::*;

  localparam int ELEMENTS       = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int RAND_PHASES    = 8;
  localparam int BEATS_PER_PHASE = 180;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [DELTA_W-1:0] delta;
    logic               sat;
    logic               last;
  } delta_beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cfg_index_t         reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [ADDR_W-1:0]  addr;
    logic [GRAD_W-1:0]  grad;
    logic               last;
    logic               fixed_exp;
    logic [DELTA_W-1:0] exp_delta;
    logic               exp_sat;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aeu_in_if  in_ch ();
  aeu_out_if out_ch ();

  adam_element_update_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the registers and moment stores.
  logic [LR_W-1:0]    lr_q;
  logic [BETA_W-1:0]  beta1_q, beta2_q, pow1_q, pow2_q;
  logic [EPS_W-1:0]   eps_q;
  logic [BATCH_W-1:0] batch_q;
  logic signed [STORE_W-1:0] first_mom [ELEMENTS];
  logic [STORE_W-1:0]        second_mom [ELEMENTS];

  delta_beat_t pending_deltas[$];
  int mismatches;
  int beats_sent;
  int src_idle_pct;
  int snk_idle_pct;
  int quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Register write as the block sees it; upper bits of narrow fields drop.
  function automatic void shadow_reg_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_LEARNING_RATE:     lr_q = val[LR_W-1:0];
      CFG_BETA_FIRST:        beta1_q = val[BETA_W-1:0];
      CFG_BETA_SECOND:       beta2_q = val[BETA_W-1:0];
      CFG_BETA_FIRST_POWER:  pow1_q = val[BETA_W-1:0];
      CFG_BETA_SECOND_POWER: pow2_q = val[BETA_W-1:0];
      CFG_EPSILON_TERM:      eps_q = val[EPS_W-1:0];
      CFG_BATCH_COUNT:       batch_q = val[BATCH_W-1:0];
      default: ;
    endcase
  endfunction

  // Adam step for one element: moment update, bias correction, scaled delta.
  function automatic delta_beat_t adam_delta(logic [ADDR_W-1:0] addr,
                                             logic signed [GRAD_W-1:0] grad,
                                             logic last);
    delta_beat_t res;
    longint gs, g, m, mn;
    longint unsigned bc, gabs, gmag, gg, vn, mabs, mhat, vhat, den, q, mag, dval;
    longint unsigned pos_max, neg_max;
    logic gneg, mneg, sat;
    int a;
    a = addr % ELEMENTS;
    gs = grad;
    bc = (batch_q == 0) ? 64'd1 : 64'(batch_q);
    gneg = gs < 0;
    gabs = gneg ? longint'(-gs) : longint'(gs);
    gmag = gabs / bc;
    g = gneg ? -longint'(gmag) : longint'(gmag);

    m = first_mom[a];
    mn = (longint'(beta1_q) * m + (longint'(65536) - longint'(beta1_q)) * g) >>> 16;
    first_mom[a] = mn[STORE_W-1:0];

    gg = (gmag * gmag) >> 16;
    if (gg > 64'hFFFF_FFFF) gg = 64'hFFFF_FFFF;
    vn = (64'(beta2_q) * 64'(second_mom[a]) + (64'd65536 - 64'(beta2_q)) * gg) >> 16;
    second_mom[a] = vn[STORE_W-1:0];

    mneg = mn < 0;
    mabs = mneg ? longint'(-mn) : longint'(mn);
    mhat = (mabs << 16) / (64'd65536 - 64'(pow1_q));
    vhat = (vn << 16) / (64'd65536 - 64'(pow2_q));
    den = int_sqrt(vhat << 16) + 64'(eps_q);

    pos_max = (64'd1 << 31) - 1;
    neg_max = 64'd1 << 31;
    dval = 0;
    sat = 1'b0;
    if (den != 0) begin
      q = (mhat << 16) / den;
      if (lr_q == 0) mag = 0;
      else if (q >= (64'd1 << 47)) mag = '1;
      else mag = (q * 64'(lr_q)) >> 16;
      if (mneg) begin
        if (mag > pos_max) begin
          mag = pos_max;
          sat = 1'b1;
        end
        dval = mag;
      end else begin
        if (mag > neg_max) begin
          mag = neg_max;
          sat = 1'b1;
        end
        dval = 64'd0 - mag;
      end
    end
    res.addr = addr;
    res.delta = dval[DELTA_W-1:0];
    res.sat = sat;
    res.last = last;
    return res;
  endfunction

  // Result side: random stall, compare each beat, watchdog on silence.
  always @(posedge clk) begin
    delta_beat_t want;
    logic moved;
    moved = 1'b0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (in_ch.valid && in_ch.ready) moved = 1'b1;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_deltas.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: addr %0d delta %h", out_ch.result_address,
                     out_ch.weight_delta);
        end else begin
          want = pending_deltas.pop_front();
          if (out_ch.result_address !== want.addr || out_ch.weight_delta !== want.delta ||
              out_ch.saturated !== want.sat || out_ch.last_out !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp addr %0d delta %h sat %b last %b, got %0d %h %b %b",
                       want.addr, want.delta, want.sat, want.last, out_ch.result_address,
                       out_ch.weight_delta, out_ch.saturated, out_ch.last_out);
          end
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[adam_element_update_core] ERROR");
      $finish;
    end
  end

  // One register write; the write enable is then driven low again before the task returns.
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    shadow_reg_write(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one beat with a random leading gap; predict when it is taken.
  task automatic send_beat(logic [ADDR_W-1:0] addr, logic [GRAD_W-1:0] grad, logic last,
                           logic fixed_exp, logic [DELTA_W-1:0] exp_delta, logic exp_sat);
    delta_beat_t want;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.element_address <= addr;
    in_ch.gradient_sum <= grad;
    in_ch.last_in <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = adam_delta(addr, grad, last);
    if (fixed_exp) begin
      want.delta = exp_delta;
      want.sat = exp_sat;
    end
    pending_deltas.insert(pending_deltas.size(), want);
    beats_sent++;
    if (beats_sent < 480) begin
      src_idle_pct = 30;
      snk_idle_pct = 66;
    end else if (beats_sent < 960) begin
      src_idle_pct = 66;
      snk_idle_pct = 30;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
  endtask

  // Hold off the sender until the block has drained.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_deltas.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg(int lo, int hi);
    case ($urandom_range(0, 4))
      0: return CFG_DATA_W'(lo);
      1: return CFG_DATA_W'(hi);
      2: return CFG_DATA_W'($urandom_range(lo, hi));
      3: return CFG_DATA_W'($urandom_range(0, 131071));
      default: return CFG_DATA_W'($urandom_range(lo, (lo + 64 < hi) ? lo + 64 : hi));
    endcase
  endfunction

  function automatic logic [GRAD_W-1:0] pick_grad();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3, 4: return $urandom_range(0, 32'h3_FFFF) * ($urandom_range(0, 1) ? 1 : -1);
      default: return $urandom;
    endcase
  endfunction

  // Directed rows: extremes, forwarding on one address and the special cases.
  stim_row_t directed [] = '{
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd0, 32'h0000_0000, 1'b0, 1'b1, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd4095, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd4095, 32'h8000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd5, 32'h0001_0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd5, 32'h0001_0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd5, 32'hFFFF_0000, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, CFG_BATCH_COUNT, 17'd0, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd7, 32'h0003_0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, CFG_EPSILON_TERM, 17'd0, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd100, 32'h0000_0000, 1'b0, 1'b1, 32'd0, 1'b0},
    '{ROW_CFG, CFG_BETA_SECOND, 17'd65535, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, CFG_LEARNING_RATE, 17'd65536, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd200, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd201, 32'h0000_0001, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd201, 32'h8000_0000, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, CFG_BETA_FIRST_POWER, 17'h1FFFF, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, CFG_BETA_FIRST, 17'h1FFFF, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_CFG, CFG_BETA_SECOND_POWER, 17'd0, 12'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd3, 32'h1234_5678, 1'b1, 1'b0, 32'd0, 1'b0},
    '{ROW_BEAT, CFG_LEARNING_RATE, 17'd0, 12'd3, 32'hEDCB_A988, 1'b0, 1'b0, 32'd0, 1'b0}
  };

  // Stimulus: reset, directed table, then randomized register phases.
  initial begin
    logic [ADDR_W-1:0] addr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LEARNING_RATE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.element_address = '0;
    in_ch.gradient_sum = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    beats_sent = 0;
    quiet_cycles = 0;
    src_idle_pct = 30;
    snk_idle_pct = 66;
    lr_q = 66;
    beta1_q = 58982;
    beta2_q = 65470;
    pow1_q = 58982;
    pow2_q = 65470;
    eps_q = 1;
    batch_q = 1;
    for (int i = 0; i < ELEMENTS; i++) begin
      first_mom[i] = '0;
      second_mom[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_beat(directed[i].addr, directed[i].grad, directed[i].last,
                  directed[i].fixed_exp, directed[i].exp_delta, directed[i].exp_sat);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      write_reg(CFG_LEARNING_RATE, pick_reg(0, 65536));
      write_reg(CFG_BETA_FIRST, pick_reg(0, 65535));
      write_reg(CFG_BETA_SECOND, pick_reg(0, 65535));
      write_reg(CFG_BETA_FIRST_POWER, pick_reg(0, 65535));
      write_reg(CFG_BETA_SECOND_POWER, pick_reg(0, 65535));
      write_reg(CFG_EPSILON_TERM, pick_reg(0, 65536));
      write_reg(CFG_BATCH_COUNT, pick_reg(1, 65535));
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // A narrow address pool makes back-to-back hits on one element common.
        addr = ($urandom_range(0, 1)) ? 12'($urandom_range(0, 15)) : 12'($urandom);
        send_beat(addr, pick_grad(), 1'($urandom_range(0, 1)), 1'b0, '0, 1'b0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_deltas.size() == 0)
      $display("[adam_element_update_core] OK");
    else
      $display("[adam_element_update_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/aeu_pkg.sv
sv/aeu_in_if.sv
sv/aeu_out_if.sv
sv/aeu_ram.sv
sv/aeu_div.sv
sv/aeu_sqrt.sv
sv/adam_element_update_core.sv
tb/adam_element_update_core_tb.sv
